@@ rtl/acfp_pkg.sv @@
// Shared types, constants and the decode microprogram of the ASCII command frame parser.
// Depends on nothing; acfp_capture and the core refer to it by scoped names.
package acfp_pkg;

  // Frame buffer geometry.
  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int FILL_W      = $clog2(FRAME_DEPTH + 1);
  // The scan index can run up to five places past the buffered bytes.
  localparam int IDX_W       = $clog2(FRAME_DEPTH + 6);

  localparam int NUM_CMDS    = 8;
  localparam int CMD_W       = 3;
  localparam int PARAM_SLOTS = 5;
  localparam int PCNT_W      = 3;
  localparam int VAL_W       = 32;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_END = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END     = 2'd2;
  localparam logic [7:0] START_RST   = 8'h24;
  localparam logic [7:0] PRE_END_RST = 8'h0D;
  localparam logic [7:0] END_RST     = 8'h0A;

  // Command table: four letters each, first letter in the top byte.
  localparam logic [31:0] CMD_NAMES [NUM_CMDS] = '{
    "RVER", "CARB", "PRSW", "STRT", "STOP", "HOME", "INJC", "GIST"
  };
  localparam logic [PCNT_W-1:0] CMD_PARAMS [NUM_CMDS] = '{
    3'd0, 3'd5, 3'd0, 3'd3, 3'd0, 3'd2, 3'd2, 3'd0
  };

  // Letter at position pos of command cmd.
  function automatic logic [7:0] cmd_letter(input logic [CMD_W-1:0] cmd,
                                            input logic [1:0] pos);
    logic [31:0] w;
    w = CMD_NAMES[cmd] >> {~pos, 3'b000};
    return w[7:0];
  endfunction

  // Framing symbols handed to the capture stage.
  typedef struct packed {
    logic [7:0] start_sym;
    logic [7:0] pre_sym;
    logic [7:0] end_sym;
  } sym_t;

  // A complete, well framed frame is ready for decoding.
  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] len;
  } frame_go_t;

  // Read request into the frame buffer.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FETCH,
    OP_MATCH,
    OP_SELECT,
    OP_INC,
    OP_ACCUM,
    OP_STORE,
    OP_ILLEGAL,
    OP_LEGAL
  } op_t;

  // Jump condition of one microcode step.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_SHORT,
    C_LETTERS_LEFT,
    C_NO_MATCH,
    C_NO_PARAMS,
    C_NOT_SPACE,
    C_TERM,
    C_NOT_DIGIT,
    C_IS_PRE,
    C_MORE,
    C_FINAL_OK
  } cond_t;

  localparam int STEP_W = 5;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Step numbers of the program.
  localparam logic [STEP_W-1:0] S_LOAD       = 5'd0;
  localparam logic [STEP_W-1:0] S_FETCH_LTR  = 5'd1;
  localparam logic [STEP_W-1:0] S_MATCH      = 5'd2;
  localparam logic [STEP_W-1:0] S_SELECT     = 5'd3;
  localparam logic [STEP_W-1:0] S_WANT       = 5'd4;
  localparam logic [STEP_W-1:0] S_FETCH_SP   = 5'd5;
  localparam logic [STEP_W-1:0] S_SPACE      = 5'd6;
  localparam logic [STEP_W-1:0] S_FETCH_DIG  = 5'd7;
  localparam logic [STEP_W-1:0] S_TERM       = 5'd8;
  localparam logic [STEP_W-1:0] S_DIGIT      = 5'd9;
  localparam logic [STEP_W-1:0] S_ACCUM      = 5'd10;
  localparam logic [STEP_W-1:0] S_STORE      = 5'd11;
  localparam logic [STEP_W-1:0] S_NEXT       = 5'd12;
  localparam logic [STEP_W-1:0] S_FETCH_END  = 5'd13;
  localparam logic [STEP_W-1:0] S_CHECK      = 5'd14;
  localparam logic [STEP_W-1:0] S_ILLEGAL    = 5'd15;
  localparam logic [STEP_W-1:0] S_LEGAL      = 5'd16;

  // Decode program. A step without a taken jump falls through to the next one;
  // the two reporting steps end the program.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t cw;
    cw = '{op: OP_NONE, cond: C_NEVER, target: S_LOAD};
    unique case (step)
      S_LOAD:      cw = '{op: OP_LOAD,    cond: C_SHORT,        target: S_ILLEGAL};
      S_FETCH_LTR: cw = '{op: OP_FETCH,   cond: C_NEVER,        target: S_LOAD};
      S_MATCH:     cw = '{op: OP_MATCH,   cond: C_LETTERS_LEFT, target: S_FETCH_LTR};
      S_SELECT:    cw = '{op: OP_SELECT,  cond: C_NO_MATCH,     target: S_ILLEGAL};
      S_WANT:      cw = '{op: OP_NONE,    cond: C_NO_PARAMS,    target: S_LEGAL};
      S_FETCH_SP:  cw = '{op: OP_FETCH,   cond: C_NEVER,        target: S_LOAD};
      S_SPACE:     cw = '{op: OP_INC,     cond: C_NOT_SPACE,    target: S_ILLEGAL};
      S_FETCH_DIG: cw = '{op: OP_FETCH,   cond: C_NEVER,        target: S_LOAD};
      S_TERM:      cw = '{op: OP_NONE,    cond: C_TERM,         target: S_STORE};
      S_DIGIT:     cw = '{op: OP_NONE,    cond: C_NOT_DIGIT,    target: S_ILLEGAL};
      S_ACCUM:     cw = '{op: OP_ACCUM,   cond: C_ALWAYS,       target: S_FETCH_DIG};
      S_STORE:     cw = '{op: OP_STORE,   cond: C_IS_PRE,       target: S_CHECK};
      S_NEXT:      cw = '{op: OP_INC,     cond: C_MORE,         target: S_FETCH_DIG};
      S_FETCH_END: cw = '{op: OP_FETCH,   cond: C_NEVER,        target: S_LOAD};
      S_CHECK:     cw = '{op: OP_NONE,    cond: C_FINAL_OK,     target: S_LEGAL};
      S_ILLEGAL:   cw = '{op: OP_ILLEGAL, cond: C_NEVER,        target: S_LOAD};
      S_LEGAL:     cw = '{op: OP_LEGAL,   cond: C_NEVER,        target: S_LOAD};
      default:     cw = '{op: OP_ILLEGAL, cond: C_NEVER,        target: S_LOAD};
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/acfp_chan_if.sv @@
// Valid/ready channels of the ASCII command frame parser: received bytes in, results out.
// Depends on nothing.
interface acfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink   (input valid, rx_byte, output ready);
endinterface

interface acfp_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [2:0]  command;
  logic [31:0] param_one;
  logic [31:0] param_two;
  logic [31:0] param_three;
  logic [31:0] param_four;
  logic [31:0] param_five;
  logic [31:0] illegal_total;

  modport source (output valid, status, command, param_one, param_two, param_three,
                  param_four, param_five, illegal_total, input ready);
  modport sink   (input valid, status, command, param_one, param_two, param_three,
                  param_four, param_five, illegal_total, output ready);
endinterface

@@ rtl/acfp_capture.sv @@
// Frame capture: start hunting, byte buffering, overflow and end-of-frame checks.
// Depends on acfp_pkg and the acfp_rx_if channel; holds the frame buffer memory.
module acfp_capture (
  input  logic                  clk,
  input  logic                  rst,
  acfp_rx_if.sink               rx,
  input  acfp_pkg::sym_t        sym,
  input  logic                  busy,
  output acfp_pkg::frame_go_t   go,
  input  acfp_pkg::rd_req_t     rd_req,
  output logic [7:0]            rd_data
);

  logic [7:0]                    mem [acfp_pkg::FRAME_DEPTH];
  logic                          in_frame;
  logic [acfp_pkg::FILL_W-1:0]   fill_index;
  logic [acfp_pkg::FILL_W-1:0]   fill_inc;
  logic [7:0]                    last_byte;
  logic                          take;
  logic                          is_end;

  // Bytes are taken whenever no decode is running.
  assign rx.ready = !busy;
  assign take     = rx.valid && !busy;
  assign is_end   = rx.rx_byte == sym.end_sym;
  assign fill_inc = fill_index + 1'b1;

  // A frame is handed on only if it holds bytes and ends in the pre-end symbol.
  assign go.start = take && in_frame && is_end && (fill_index != '0) &&
                    (last_byte == sym.pre_sym);
  assign go.len   = fill_index;

  // Framing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      fill_index <= '0;
    end else if (take) begin
      if (!in_frame) begin
        if (rx.rx_byte == sym.start_sym) begin
          in_frame   <= 1'b1;
          fill_index <= '0;
        end
      end else if (is_end) begin
        in_frame   <= 1'b0;
        fill_index <= '0;
      end else if (fill_inc >= acfp_pkg::FILL_W'(acfp_pkg::FRAME_DEPTH)) begin
        in_frame   <= 1'b0;
        fill_index <= '0;
      end else begin
        fill_index <= fill_inc;
      end
    end
  end

  // Frame buffer write and the copy of the newest byte.
  always_ff @(posedge clk) begin
    if (take && in_frame && !is_end) begin
      mem[fill_index[acfp_pkg::ADDR_W-1:0]] <= rx.rx_byte;
      last_byte                             <= rx.rx_byte;
    end
  end

  // Registered read port for the decoder.
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule

@@ rtl/ascii_command_frame_parser_core.sv @@
// Top level of the ASCII command frame parser: configuration registers, the microcoded
// decode sequencer with its datapath, and the result register.
// Depends on acfp_pkg, acfp_chan_if and acfp_capture.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------------
//   rx       | in  | valid/ready        | rx_byte
//   result   | out | valid/ready        | status, command, param_one..five, illegal_total
//   cfg      | in  | cfg_we, no wait    | cfg_index, cfg_data
//
// A byte is taken whenever no decode is running. A byte that closes a good frame
// starts the decode program, which walks the frame buffer through one read port with
// registered data; rx.ready is low while it runs. The result register frees the
// sequencer while a result waits; the last step holds while an earlier result is
// still unread. Reset is synchronous, and the frame buffer needs no clearing.
module ascii_command_frame_parser_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [acfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  acfp_rx_if.sink                        rx,
  acfp_res_if.source                     result
);

  acfp_pkg::sym_t       sym;
  acfp_pkg::frame_go_t  go;
  acfp_pkg::rd_req_t    rd_req;
  logic [7:0]           rd_data;

  logic                              busy;
  logic [acfp_pkg::STEP_W-1:0]       pc;
  acfp_pkg::ucode_t                  cw;
  logic [acfp_pkg::FILL_W-1:0]       n;
  logic [acfp_pkg::IDX_W-1:0]        idx;
  logic [acfp_pkg::NUM_CMDS-1:0]     mask;
  logic [acfp_pkg::NUM_CMDS-1:0]     mask_next;
  logic [acfp_pkg::CMD_W-1:0]        cmd;
  logic [acfp_pkg::CMD_W-1:0]        cmd_next;
  logic [acfp_pkg::PCNT_W-1:0]       want;
  logic [acfp_pkg::PCNT_W-1:0]       count;
  logic [acfp_pkg::VAL_W-1:0]        v;
  logic [acfp_pkg::VAL_W-1:0]        vals [acfp_pkg::PARAM_SLOTS];
  logic [31:0]                       illegal_cnt;

  logic [7:0]  c;
  logic        in_range;
  logic        is_digit;
  logic [3:0]  digit;
  logic        jump;
  logic        is_emit;
  logic        out_free;
  logic        act;

  logic                              out_valid;
  logic                              out_status;
  logic [acfp_pkg::CMD_W-1:0]        out_command;
  logic [acfp_pkg::VAL_W-1:0]        out_vals [acfp_pkg::PARAM_SLOTS];
  logic [31:0]                       out_total;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sym.start_sym <= acfp_pkg::START_RST;
      sym.pre_sym   <= acfp_pkg::PRE_END_RST;
      sym.end_sym   <= acfp_pkg::END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acfp_pkg::REG_START:   sym.start_sym <= cfg_data;
        acfp_pkg::REG_PRE_END: sym.pre_sym   <= cfg_data;
        acfp_pkg::REG_END:     sym.end_sym   <= cfg_data;
        default: ;
      endcase
    end
  end

  acfp_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .sym     (sym),
    .busy    (busy),
    .go      (go),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  // Current control word and the byte under the scan index.
  assign cw       = acfp_pkg::ucode(pc);
  assign in_range = idx < acfp_pkg::IDX_W'(n);
  assign c        = in_range ? rd_data : sym.end_sym;
  assign is_digit = (c >= acfp_pkg::DIGIT_LO) && (c <= acfp_pkg::DIGIT_HI);
  assign digit    = 4'(c - acfp_pkg::DIGIT_LO);
  assign want     = acfp_pkg::CMD_PARAMS[cmd];

  assign rd_req.en   = busy && (cw.op == acfp_pkg::OP_FETCH);
  assign rd_req.addr = idx[acfp_pkg::ADDR_W-1:0];

  // The reporting steps wait for room in the result register.
  assign out_free = !out_valid || result.ready;
  assign is_emit  = (cw.op == acfp_pkg::OP_ILLEGAL) || (cw.op == acfp_pkg::OP_LEGAL);
  assign act      = busy && (!is_emit || out_free);

  // Jump condition select.
  always_comb begin
    unique case (cw.cond)
      acfp_pkg::C_NEVER:        jump = 1'b0;
      acfp_pkg::C_ALWAYS:       jump = 1'b1;
      acfp_pkg::C_SHORT:        jump = n < acfp_pkg::FILL_W'(5);
      acfp_pkg::C_LETTERS_LEFT: jump = idx[1:0] != 2'd3;
      acfp_pkg::C_NO_MATCH:     jump = mask == '0;
      acfp_pkg::C_NO_PARAMS:    jump = want == '0;
      acfp_pkg::C_NOT_SPACE:    jump = c != acfp_pkg::SPACE_CHAR;
      acfp_pkg::C_TERM:         jump = !in_range || (c == acfp_pkg::COMMA_CHAR) ||
                                       (c == sym.pre_sym);
      acfp_pkg::C_NOT_DIGIT:    jump = !is_digit;
      acfp_pkg::C_IS_PRE:       jump = c == sym.pre_sym;
      acfp_pkg::C_MORE:         jump = count < want;
      acfp_pkg::C_FINAL_OK:     jump = (count == want) && (c == sym.pre_sym);
      default:                  jump = 1'b0;
    endcase
  end

  // Letter compare against every command, and the index of the surviving one.
  always_comb begin
    mask_next = mask;
    cmd_next  = '0;
    for (int k = 0; k < acfp_pkg::NUM_CMDS; k++) begin
      if (c != acfp_pkg::cmd_letter(acfp_pkg::CMD_W'(k), idx[1:0])) begin
        mask_next[k] = 1'b0;
      end
    end
    for (int k = acfp_pkg::NUM_CMDS - 1; k >= 0; k--) begin
      if (mask[k]) begin
        cmd_next = acfp_pkg::CMD_W'(k);
      end
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= acfp_pkg::S_LOAD;
    end else if (!busy) begin
      if (go.start) begin
        busy <= 1'b1;
        pc   <= acfp_pkg::S_LOAD;
      end
    end else if (act) begin
      if (is_emit) begin
        busy <= 1'b0;
      end else if (jump) begin
        pc <= cw.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  // Decode datapath.
  always_ff @(posedge clk) begin
    if (!busy && go.start) begin
      n <= go.len;
    end
    if (act) begin
      case (cw.op)
        acfp_pkg::OP_LOAD: begin
          idx   <= '0;
          mask  <= '1;
          count <= '0;
          v     <= '0;
          for (int k = 0; k < acfp_pkg::PARAM_SLOTS; k++) begin
            vals[k] <= '0;
          end
        end
        acfp_pkg::OP_MATCH: begin
          mask <= mask_next;
          idx  <= idx + 1'b1;
        end
        acfp_pkg::OP_SELECT: cmd <= cmd_next;
        acfp_pkg::OP_INC:    idx <= idx + 1'b1;
        acfp_pkg::OP_ACCUM: begin
          v   <= (v << 3) + (v << 1) + acfp_pkg::VAL_W'(digit);
          idx <= idx + 1'b1;
        end
        acfp_pkg::OP_STORE: begin
          vals[count] <= v;
          count       <= count + 1'b1;
          v           <= '0;
        end
        default: ;
      endcase
    end
  end

  // Illegal command counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      illegal_cnt <= '0;
    end else if (act && (cw.op == acfp_pkg::OP_ILLEGAL)) begin
      illegal_cnt <= illegal_cnt + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (act && is_emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act && (cw.op == acfp_pkg::OP_ILLEGAL)) begin
      out_status  <= 1'b1;
      out_command <= '0;
      out_total   <= illegal_cnt + 1'b1;
      for (int k = 0; k < acfp_pkg::PARAM_SLOTS; k++) begin
        out_vals[k] <= '0;
      end
    end else if (act && (cw.op == acfp_pkg::OP_LEGAL)) begin
      out_status  <= 1'b0;
      out_command <= cmd;
      out_total   <= illegal_cnt;
      for (int k = 0; k < acfp_pkg::PARAM_SLOTS; k++) begin
        out_vals[k] <= vals[k];
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.command       = out_command;
  assign result.param_one     = out_vals[0];
  assign result.param_two     = out_vals[1];
  assign result.param_three   = out_vals[2];
  assign result.param_four    = out_vals[3];
  assign result.param_five    = out_vals[4];
  assign result.illegal_total = out_total;

endmodule
